// ===== src/akf_pkg.sv =====
// Shared types, constants and scratch memory map of the altitude Kalman filter.
package akf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned RamDepth = 64;
  localparam int unsigned AccW     = 50;
  localparam int unsigned PaddrW   = 5;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TIME_STEP  = 3'd0;
  localparam logic [2:0] REG_HALF_STEP  = 3'd1;
  localparam logic [2:0] REG_MEAS_GAIN  = 3'd2;
  localparam logic [2:0] REG_MEAS_VAR   = 3'd3;
  localparam logic [2:0] REG_Q_POS      = 3'd4;
  localparam logic [2:0] REG_Q_VEL      = 3'd5;
  localparam logic [2:0] REG_Q_ACC      = 3'd6;
  localparam logic [2:0] REG_PRECISION  = 3'd7;

  localparam logic [CfgW-1:0]  RST_TIME_STEP = 31'd655;
  localparam logic [CfgW-1:0]  RST_HALF_STEP = 31'd3;
  localparam logic [DataW-1:0] RST_MEAS_GAIN = 32'd65536;
  localparam logic [CfgW-1:0]  RST_MEAS_VAR  = 31'd65536;
  localparam logic [CfgW-1:0]  RST_Q         = 31'd65536;
  localparam logic [CfgW-1:0]  RST_PRECISION = 31'd655;

  localparam logic [DataW-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [DataW-1:0] XINIT_Q = 32'd6554;
  localparam logic [DataW-1:0] HALF_Q  = 32'd32768;

  // scratch memory map
  localparam logic [AddrW-1:0] A_X  = 6'd0;
  localparam logic [AddrW-1:0] A_P  = 6'd3;
  localparam logic [AddrW-1:0] A_KL = 6'd12;
  localparam logic [AddrW-1:0] A_XP = 6'd15;
  localparam logic [AddrW-1:0] A_T  = 6'd18;
  localparam logic [AddrW-1:0] A_PP = 6'd27;
  localparam logic [AddrW-1:0] A_HP = 6'd36;
  localparam logic [AddrW-1:0] A_PH = 6'd39;
  localparam logic [AddrW-1:0] A_K  = 6'd42;
  localparam logic [AddrW-1:0] A_M  = 6'd45;
  localparam logic [AddrW-1:0] A_HX = 6'd54;
  localparam logic [AddrW-1:0] A_Y  = 6'd55;
  localparam logic [AddrW-1:0] A_S  = 6'd56;

  // constant operand ids
  localparam logic [AddrW-1:0] C_ZERO  = 6'd0;
  localparam logic [AddrW-1:0] C_ONE   = 6'd1;
  localparam logic [AddrW-1:0] C_DT    = 6'd2;
  localparam logic [AddrW-1:0] C_HS    = 6'd3;
  localparam logic [AddrW-1:0] C_G     = 6'd4;
  localparam logic [AddrW-1:0] C_R     = 6'd5;
  localparam logic [AddrW-1:0] C_Q0    = 6'd6;
  localparam logic [AddrW-1:0] C_Q1    = 6'd7;
  localparam logic [AddrW-1:0] C_Q2    = 6'd8;
  localparam logic [AddrW-1:0] C_XINIT = 6'd9;
  localparam logic [AddrW-1:0] C_HALF  = 6'd10;
  localparam logic [AddrW-1:0] C_Z     = 6'd11;

  typedef struct packed {
    logic             is_const;
    logic [AddrW-1:0] idx;
  } src_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MAC, OP_MSUB, OP_SUB, OP_STORE, OP_DIV, OP_FLAG, OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    PH_INIT, PH_XP, PH_T, PH_PP, PH_HX, PH_Y, PH_HP, PH_S, PH_PH, PH_K, PH_XU,
    PH_M, PH_PU, PH_FLAG, PH_OUT
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_MULT, ST_EXEC, ST_DIVW, ST_OWAIT
  } state_e;

  typedef struct packed {
    op_e              op;
    src_t             src_a;
    src_t             src_b;
    logic [AddrW-1:0] dst;
    logic             start;
    logic             mul_en;
    logic             exec_en;
    logic             publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [CfgW-1:0]  time_step;
    logic [CfgW-1:0]  half_step_squared;
    logic [DataW-1:0] meas_gain;
    logic [CfgW-1:0]  meas_variance;
    logic [CfgW-1:0]  q_position;
    logic [CfgW-1:0]  q_velocity;
    logic [CfgW-1:0]  q_acceleration;
    logic [CfgW-1:0]  settle_precision;
  } cfg_t;

endpackage

// ===== src/akf_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module akf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== src/akf_div.sv =====
// Bit-serial restoring divider for the gain, rounded half away from zero, saturated.
module akf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import akf_pkg::*;

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [48:0] n_q, n_d;
  logic [32:0] rem_q, rem_d, dd_q;
  logic [31:0] quot_q;
  logic [32:0] un, ud;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    un = num_i[31] ? 33'(-$signed({num_i[31], num_i})) : {1'b0, num_i};
    ud = den_i[31] ? 33'(-$signed({den_i[31], den_i})) : {1'b0, den_i};
    trial = {rem_q, n_q[48]};
    ge = trial >= {1'b0, dd_q};
    rem_d = ge ? 33'(trial - {1'b0, dd_q}) : trial[32:0];
    n_d = {n_q[47:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd48) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // dividend 2*|num|*2^16 + |den|, divisor 2*|den|
      n_q    <= {un[31:0], 17'b0} + 49'(ud);
      dd_q   <= {ud[31:0], 1'b0};
      rem_q  <= '0;
      neg_q  <= num_i[31] ^ den_i[31];
      quot_q <= '0;
    end else if (busy_q) begin
      n_q   <= n_d;
      rem_q <= rem_d;
      if (cnt_q == 6'd48) begin
        if (!neg_q) begin
          quot_q <= (n_d > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : n_d[31:0];
        end else begin
          quot_q <= (n_d > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(32'd0 - n_d[31:0]);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/akf_ctrl.sv =====
// Sequencer: walks the predict and update steps one micro-operation at a time.
module akf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  akf_pkg::stat_t stat_i,
  output akf_pkg::cmd_t  cmd_o
);
  import akf_pkg::*;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [3:0] e_q, e_d;
  logic [2:0] u_q, u_d;
  logic       loaded_q, loaded_d;

  src_t       init_src, mac_a, mac_b;
  op_e        mac_op, single_op;
  logic [2:0] nmac, u_last;
  logic [3:0] last_e;
  logic [AddrW-1:0] dst;
  logic       single, adv;
  logic [1:0] i, j, n, pi, pj;

  function automatic src_t ram_src(logic [AddrW-1:0] a);
    return '{is_const: 1'b0, idx: a};
  endfunction

  function automatic src_t cst(logic [AddrW-1:0] c);
    return '{is_const: 1'b1, idx: c};
  endfunction

  // entries of the motion matrix
  function automatic src_t a_src(logic [1:0] r, logic [1:0] c);
    if (r == c) return cst(C_ONE);
    else if (c == 2'(r + 2'd1)) return cst(C_DT);
    else if (r == 2'd0 && c == 2'd2) return cst(C_HS);
    else return cst(C_ZERO);
  endfunction

  function automatic logic [1:0] row(logic [3:0] e);
    return (e >= 4'd6) ? 2'd2 : (e >= 4'd3) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] col(logic [3:0] e);
    logic [3:0] t;
    t = 4'(e - 4'(row(e)) * 4'd3);
    return t[1:0];
  endfunction

  function automatic logic [AddrW-1:0] idx3(logic [1:0] r, logic [1:0] c);
    return 6'(6'(r) * 6'd3 + 6'(c));
  endfunction

  function automatic logic [AddrW-1:0] q_id(logic [1:0] r);
    return 6'(C_Q0 + 6'(r));
  endfunction

  function automatic phase_e next_phase(phase_e p);
    phase_e r;
    unique case (p)
      PH_INIT: r = PH_XP;
      PH_XP:   r = PH_T;
      PH_T:    r = PH_PP;
      PH_PP:   r = PH_HX;
      PH_HX:   r = PH_Y;
      PH_Y:    r = PH_HP;
      PH_HP:   r = PH_S;
      PH_S:    r = PH_PH;
      PH_PH:   r = PH_K;
      PH_K:    r = PH_XU;
      PH_XU:   r = PH_M;
      PH_M:    r = PH_PU;
      PH_PU:   r = PH_FLAG;
      PH_FLAG: r = PH_OUT;
      default: r = PH_OUT;
    endcase
    return r;
  endfunction

  // micro-operation decode for the current phase, element and step
  always_comb begin
    i = row(e_q);
    j = col(e_q);
    n = 2'(u_q - 3'd1);
    pi = row(4'(e_q - 4'd3));
    pj = col(4'(e_q - 4'd3));
    init_src  = cst(C_ZERO);
    mac_op    = OP_MAC;
    mac_a     = cst(C_ZERO);
    mac_b     = cst(C_ZERO);
    nmac      = 3'd0;
    dst       = '0;
    last_e    = 4'd0;
    single    = 1'b0;
    single_op = OP_NOP;
    unique case (phase_q)
      PH_INIT: begin
        // scratch entries 0..14 hold state, covariance and previous gain
        if (e_q < 4'd3) begin
          init_src = (e_q == 4'd0) ? cst(C_XINIT) : cst(C_ZERO);
        end else if (e_q < 4'd12) begin
          init_src = (pi == pj) ? cst(q_id(pi)) : cst(C_ZERO);
        end else begin
          init_src = cst(C_HALF);
        end
        dst    = 6'(e_q);
        last_e = 4'd14;
      end
      PH_XP: begin
        mac_a = a_src(2'(e_q), n);
        mac_b = ram_src(6'(A_X + 6'(n)));
        nmac = 3'd3; dst = 6'(A_XP + 6'(e_q)); last_e = 4'd2;
      end
      PH_T: begin
        mac_a = a_src(i, n);
        mac_b = ram_src(6'(A_P + idx3(n, j)));
        nmac = 3'd3; dst = 6'(A_T + 6'(e_q)); last_e = 4'd8;
      end
      PH_PP: begin
        init_src = (i == j) ? cst(q_id(i)) : cst(C_ZERO);
        mac_a = ram_src(6'(A_T + idx3(i, n)));
        mac_b = a_src(j, n);
        nmac = 3'd3; dst = 6'(A_PP + 6'(e_q)); last_e = 4'd8;
      end
      PH_HX: begin
        mac_a = cst(C_G);
        mac_b = ram_src(A_XP);
        nmac = 3'd1; dst = A_HX;
      end
      PH_Y: begin
        init_src = cst(C_Z);
        mac_op = OP_SUB;
        mac_a = ram_src(A_HX);
        nmac = 3'd1; dst = A_Y;
      end
      PH_HP: begin
        mac_a = cst(C_G);
        mac_b = ram_src(6'(A_PP + 6'(e_q)));
        nmac = 3'd1; dst = 6'(A_HP + 6'(e_q)); last_e = 4'd2;
      end
      PH_S: begin
        init_src = cst(C_R);
        mac_a = ram_src(A_HP);
        mac_b = cst(C_G);
        nmac = 3'd1; dst = A_S;
      end
      PH_PH: begin
        mac_a = ram_src(6'(A_PP + idx3(2'(e_q), 2'd0)));
        mac_b = cst(C_G);
        nmac = 3'd1; dst = 6'(A_PH + 6'(e_q)); last_e = 4'd2;
      end
      PH_K: begin
        single = 1'b1; single_op = OP_DIV;
        mac_a = ram_src(6'(A_PH + 6'(e_q)));
        mac_b = ram_src(A_S);
        dst = 6'(A_K + 6'(e_q)); last_e = 4'd2;
      end
      PH_XU: begin
        init_src = ram_src(6'(A_XP + 6'(e_q)));
        mac_a = ram_src(6'(A_K + 6'(e_q)));
        mac_b = ram_src(A_Y);
        nmac = 3'd1; dst = 6'(A_X + 6'(e_q)); last_e = 4'd2;
      end
      PH_M: begin
        init_src = (i == j) ? cst(C_ONE) : cst(C_ZERO);
        mac_op = OP_MSUB;
        mac_a = ram_src(6'(A_K + 6'(i)));
        mac_b = cst(C_G);
        // only the first column of K*H is nonzero
        nmac = (j == 2'd0) ? 3'd1 : 3'd0;
        dst = 6'(A_M + 6'(e_q)); last_e = 4'd8;
      end
      PH_PU: begin
        mac_a = ram_src(6'(A_M + idx3(i, n)));
        mac_b = ram_src(6'(A_PP + idx3(n, j)));
        nmac = 3'd3; dst = 6'(A_P + 6'(e_q)); last_e = 4'd8;
      end
      PH_FLAG: begin
        single = 1'b1; single_op = OP_FLAG;
        mac_a = ram_src(6'(A_K + 6'(e_q)));
        mac_b = ram_src(6'(A_KL + 6'(e_q)));
        dst = 6'(A_KL + 6'(e_q)); last_e = 4'd2;
      end
      PH_OUT: begin
        single = 1'b1; single_op = OP_OUT;
        mac_a = ram_src(6'(A_X + 6'(e_q)));
        dst = 6'(e_q); last_e = 4'd2;
      end
      default: begin
        single = 1'b1;
      end
    endcase
    u_last = single ? 3'd0 : 3'(nmac + 3'd1);
  end

  // next state
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    e_d      = e_q;
    u_d      = u_q;
    loaded_d = loaded_q;
    adv      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_FETCH;
          phase_d = loaded_q ? PH_XP : PH_INIT;
          e_d = '0;
          u_d = '0;
        end
      end
      ST_FETCH: state_d = ST_MULT;
      ST_MULT:  state_d = ST_EXEC;
      ST_EXEC: begin
        if (single && single_op == OP_DIV) state_d = ST_DIVW;
        else adv = 1'b1;
      end
      ST_DIVW: begin
        if (stat_i.div_done) adv = 1'b1;
      end
      ST_OWAIT: begin
        if (!stat_i.out_busy) state_d = ST_FETCH;
      end
      default: state_d = ST_IDLE;
    endcase
    if (adv) begin
      if (u_q != u_last) begin
        u_d = 3'(u_q + 3'd1);
        state_d = ST_FETCH;
      end else if (e_q != last_e) begin
        u_d = '0;
        e_d = 4'(e_q + 4'd1);
        state_d = ST_FETCH;
      end else begin
        u_d = '0;
        e_d = '0;
        phase_d = next_phase(phase_q);
        if (phase_q == PH_INIT) loaded_d = 1'b1;
        if (phase_q == PH_OUT) state_d = ST_IDLE;
        else if (phase_q == PH_FLAG) state_d = ST_OWAIT;
        else state_d = ST_FETCH;
      end
    end
  end

  // outputs
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.start   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_en  = (state_q == ST_MULT);
    cmd_o.exec_en = (state_q == ST_EXEC);
    cmd_o.publish = (phase_q == PH_OUT) && (e_q == last_e);
    cmd_o.dst     = dst;
    cmd_o.src_b   = mac_b;
    if (single) begin
      cmd_o.op    = single_op;
      cmd_o.src_a = mac_a;
    end else if (u_q == 3'd0) begin
      cmd_o.op    = OP_LOAD;
      cmd_o.src_a = init_src;
    end else if (u_q == u_last) begin
      cmd_o.op    = OP_STORE;
      cmd_o.src_a = mac_a;
    end else begin
      cmd_o.op    = mac_op;
      cmd_o.src_a = mac_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_INIT;
      e_q      <= '0;
      u_q      <= '0;
      loaded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      e_q      <= e_d;
      u_q      <= u_d;
      loaded_q <= loaded_d;
    end
  end

endmodule

// ===== src/akf_dp.sv =====
// Datapath: scratch memory, shared multiply-accumulate, divider, flag and output words.
module akf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  akf_pkg::cfg_t       cfg_i,
  input  logic signed [31:0]  baro_altitude_i,
  input  akf_pkg::cmd_t       cmd_i,
  output akf_pkg::stat_t      stat_o,
  output logic signed [31:0]  est_altitude_o,
  output logic signed [31:0]  est_velocity_o,
  output logic signed [31:0]  est_accel_o,
  output logic                gain_settled_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import akf_pkg::*;

  localparam logic signed [AccW-1:0] SatMax = AccW'(32'h7FFF_FFFF);
  localparam logic signed [AccW-1:0] SatMin = {{(AccW-31){1'b1}}, 31'b0};

  logic signed [31:0]     z_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [63:0]     prod_q, rnd_full, lhs;
  logic signed [47:0]     rnd;
  logic [31:0]            rd_a, rd_b;
  logic signed [31:0]     opa, opb, mul_a, sat_acc, div_q;
  logic signed [32:0]     diff;
  logic                   settled_q, flag_ok, div_done;
  logic                   we;
  logic [31:0]            wdata;
  logic                   out_valid_q, settled_out_q;
  logic signed [31:0]     est_q [3];

  function automatic logic [31:0] cval(logic [AddrW-1:0] id, cfg_t c, logic [31:0] z);
    logic [31:0] v;
    case (id)
      C_ONE:   v = ONE_Q;
      C_DT:    v = {1'b0, c.time_step};
      C_HS:    v = {1'b0, c.half_step_squared};
      C_G:     v = c.meas_gain;
      C_R:     v = {1'b0, c.meas_variance};
      C_Q0:    v = {1'b0, c.q_position};
      C_Q1:    v = {1'b0, c.q_velocity};
      C_Q2:    v = {1'b0, c.q_acceleration};
      C_XINIT: v = XINIT_Q;
      C_HALF:  v = HALF_Q;
      C_Z:     v = z;
      default: v = '0;
    endcase
    return v;
  endfunction

  akf_ram #(
    .Width(DataW),
    .Depth(RamDepth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (cmd_i.dst),
    .wdata_i  (wdata),
    .raddr_a_i(cmd_i.src_a.idx),
    .raddr_b_i(cmd_i.src_b.idx),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  akf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.exec_en && cmd_i.op == OP_DIV),
    .num_i  (opa),
    .den_i  (opb),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_comb begin
    opa = cmd_i.src_a.is_const ? $signed(cval(cmd_i.src_a.idx, cfg_i, z_q)) : $signed(rd_a);
    opb = cmd_i.src_b.is_const ? $signed(cval(cmd_i.src_b.idx, cfg_i, z_q)) : $signed(rd_b);
    mul_a = (cmd_i.op == OP_FLAG) ? $signed({1'b0, cfg_i.settle_precision}) : opa;
    // Q16.16 rounding: add half, floor
    rnd_full = prod_q + 64'sd32768;
    rnd = $signed(rnd_full[63:16]);
    if (acc_q > SatMax) sat_acc = 32'sh7FFF_FFFF;
    else if (acc_q < SatMin) sat_acc = 32'sh8000_0000;
    else sat_acc = acc_q[31:0];

    // relative gain change against precision, cross-multiplied
    diff = $signed({opa[31], opa}) - $signed({opb[31], opb});
    lhs = $signed({{15{diff[32]}}, diff, 16'b0});
    if (opb[31]) flag_ok = lhs > prod_q;
    else if (opb != '0) flag_ok = lhs < prod_q;
    else flag_ok = diff[32];

    acc_d = acc_q;
    case (cmd_i.op)
      OP_LOAD: acc_d = AccW'(opa);
      OP_MAC:  acc_d = acc_q + AccW'(rnd);
      OP_MSUB: acc_d = acc_q - AccW'(rnd);
      OP_SUB:  acc_d = acc_q - AccW'(opa);
      default: acc_d = acc_q;
    endcase

    we = 1'b0;
    wdata = sat_acc;
    if (div_done) begin
      we = 1'b1;
      wdata = div_q;
    end else if (cmd_i.exec_en && cmd_i.op == OP_STORE) begin
      we = 1'b1;
    end else if (cmd_i.exec_en && cmd_i.op == OP_FLAG) begin
      we = 1'b1;
      wdata = opa;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) z_q <= baro_altitude_i;
    if (cmd_i.mul_en) prod_q <= mul_a * opb;
    if (cmd_i.exec_en) acc_q <= acc_d;
    if (cmd_i.exec_en && cmd_i.op == OP_OUT) est_q[cmd_i.dst[1:0]] <= opa;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settled_q     <= 1'b1;
      settled_out_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.start) settled_q <= 1'b1;
      else if (cmd_i.exec_en && cmd_i.op == OP_FLAG) settled_q <= settled_q & flag_ok;
      if (cmd_i.exec_en && cmd_i.op == OP_OUT && cmd_i.publish) begin
        out_valid_q   <= 1'b1;
        settled_out_q <= settled_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_valid_q;
  assign est_altitude_o  = est_q[0];
  assign est_velocity_o  = est_q[1];
  assign est_accel_o     = est_q[2];
  assign gain_settled_o  = settled_out_q;
  assign out_valid_o     = out_valid_q;

endmodule

// ===== src/altitude_kalman_filter.sv =====
// Altitude Kalman filter top level: register file, sequencer and datapath.
//
//   channel   direction  handshake                  word
//   sample    in         in_valid_i / in_ready_o    baro_altitude_i
//   estimate  out        out_valid_o / out_ready_i  est_altitude/velocity/accel, gain_settled
//   config    in         psel/penable/pwrite        paddr, pwdata, prdata
//
// One sample runs some 216 micro-operations, each through fetch, multiply and execute, on the
// single shared multiply-accumulate, plus three bit-serial gain divisions.
// The first sample after reset also runs a phase that seeds state and covariance.
// A finished word waits in the output register; the next sample is taken meanwhile and
// only its final output step stalls while the previous word is still pending.
module altitude_kalman_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [31:0]         baro_altitude_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic signed [31:0]         est_altitude_o,
  output logic signed [31:0]         est_velocity_o,
  output logic signed [31:0]         est_accel_o,
  output logic                       gain_settled_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [akf_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import akf_pkg::*;

  cfg_t       cfg_q;
  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[PaddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step         <= RST_TIME_STEP;
      cfg_q.half_step_squared <= RST_HALF_STEP;
      cfg_q.meas_gain         <= RST_MEAS_GAIN;
      cfg_q.meas_variance     <= RST_MEAS_VAR;
      cfg_q.q_position        <= RST_Q;
      cfg_q.q_velocity        <= RST_Q;
      cfg_q.q_acceleration    <= RST_Q;
      cfg_q.settle_precision  <= RST_PRECISION;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_TIME_STEP: cfg_q.time_step         <= pwdata[30:0];
        REG_HALF_STEP: cfg_q.half_step_squared <= pwdata[30:0];
        REG_MEAS_GAIN: cfg_q.meas_gain         <= pwdata;
        REG_MEAS_VAR:  cfg_q.meas_variance     <= pwdata[30:0];
        REG_Q_POS:     cfg_q.q_position        <= pwdata[30:0];
        REG_Q_VEL:     cfg_q.q_velocity        <= pwdata[30:0];
        REG_Q_ACC:     cfg_q.q_acceleration    <= pwdata[30:0];
        REG_PRECISION: cfg_q.settle_precision  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIME_STEP: prdata = {1'b0, cfg_q.time_step};
      REG_HALF_STEP: prdata = {1'b0, cfg_q.half_step_squared};
      REG_MEAS_GAIN: prdata = cfg_q.meas_gain;
      REG_MEAS_VAR:  prdata = {1'b0, cfg_q.meas_variance};
      REG_Q_POS:     prdata = {1'b0, cfg_q.q_position};
      REG_Q_VEL:     prdata = {1'b0, cfg_q.q_velocity};
      REG_Q_ACC:     prdata = {1'b0, cfg_q.q_acceleration};
      REG_PRECISION: prdata = {1'b0, cfg_q.settle_precision};
      default:       prdata = '0;
    endcase
  end

  akf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  akf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .baro_altitude_i(baro_altitude_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .est_altitude_o (est_altitude_o),
    .est_velocity_o (est_velocity_o),
    .est_accel_o    (est_accel_o),
    .gain_settled_o (gain_settled_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

`ifndef ASSERT_OFF
  // a taken sample keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer ready right after taking a sample");

  // no word can be published immediately after a sample is taken
  a_no_early_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("estimate word appeared too early");

  // words are only published by a running sequence
  a_word_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("estimate word published while idle");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the altitude Kalman filter with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import akf_pkg::*;

  localparam int unsigned StallLimit = 20000;

  typedef struct {
    logic signed [31:0] alt;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               settled;
  } estimate_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic signed [31:0]    baro_altitude_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [31:0]    est_altitude_o, est_velocity_o, est_accel_o;
  logic                  gain_settled_o, out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  altitude_kalman_filter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // filter model state and register mirror
  cfg_t               filt_cfg;
  logic signed [31:0] filt_x[3];
  logic signed [31:0] filt_p[9];
  logic signed [31:0] filt_kl[3];
  bit                 filt_p_loaded;

  logic signed [31:0] samples_pending[$];
  estimate_t          estimates_due[$];
  int unsigned        n_errors, n_samples, n_estimates, n_settings, n_settled;
  bit                 idle_on = 1'b1;
  int unsigned        in_gap, out_gap, stall_cnt;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint q;
    q = a * b + 32768;
    return q >>> 16;  // floor division by 2^16
  endfunction

  function automatic longint qdiv(longint num, longint den);
    longint unsigned un, ud, q;
    longint r;
    un = longint'(num < 0 ? -num : num) * 65536;
    ud = den < 0 ? -den : den;
    q  = (2 * un + ud) / (2 * ud);
    r  = longint'(q);
    if ((num < 0) != (den < 0)) r = -r;
    return sat32(r);
  endfunction

  // one predict/update cycle of the filter; advances the model state
  function automatic estimate_t filter_step(logic signed [31:0] z);
    longint a[9], qd[3], hv[3], xp[3], t[9], pp[9], hp[3], ph[3], k[3], m[9];
    longint acc, y, s, kl, d, lhs, rhs;
    bit ok, settled;
    estimate_t e;
    a = '{65536, longint'(filt_cfg.time_step), longint'(filt_cfg.half_step_squared),
          0, 65536, longint'(filt_cfg.time_step), 0, 0, 65536};
    qd = '{longint'(filt_cfg.q_position), longint'(filt_cfg.q_velocity),
           longint'(filt_cfg.q_acceleration)};
    hv = '{longint'($signed(filt_cfg.meas_gain)), 0, 0};
    settled = 1'b1;
    if (!filt_p_loaded) begin
      for (int i = 0; i < 9; i++) filt_p[i] = '0;
      for (int i = 0; i < 3; i++) filt_p[i*4] = 32'(qd[i]);
      filt_p_loaded = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += qmul(a[i*3+j], filt_x[j]);
      xp[i] = sat32(acc);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int n = 0; n < 3; n++) acc += qmul(a[i*3+n], filt_p[n*3+j]);
        t[i*3+j] = sat32(acc);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = (i == j) ? qd[i] : 0;
        for (int n = 0; n < 3; n++) acc += qmul(t[i*3+n], a[j*3+n]);
        pp[i*3+j] = sat32(acc);
      end
    acc = 0;
    for (int j = 0; j < 3; j++) acc += qmul(hv[j], xp[j]);
    y = sat32(longint'(z) - sat32(acc));
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int n = 0; n < 3; n++) acc += qmul(hv[n], pp[n*3+j]);
      hp[j] = sat32(acc);
    end
    acc = longint'(filt_cfg.meas_variance);
    for (int j = 0; j < 3; j++) acc += qmul(hp[j], hv[j]);
    s = sat32(acc);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int n = 0; n < 3; n++) acc += qmul(pp[i*3+n], hv[n]);
      ph[i] = sat32(acc);
      k[i] = (s == 0) ? 0 : qdiv(ph[i], s);  // zero innovation variance: predict only
    end
    for (int i = 0; i < 3; i++) filt_x[i] = 32'(sat32(xp[i] + qmul(k[i], y)));
    for (int i = 0; i < 3; i++)
      for (int n = 0; n < 3; n++)
        m[i*3+n] = sat32((i == n ? 65536 : 0) - qmul(k[i], hv[n]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int n = 0; n < 3; n++) acc += qmul(m[i*3+n], pp[n*3+j]);
        filt_p[i*3+j] = 32'(sat32(acc));
      end
    for (int i = 0; i < 3; i++) begin
      kl  = filt_kl[i];
      d   = k[i] - kl;
      lhs = d * 65536;
      rhs = longint'(filt_cfg.settle_precision) * kl;
      if (kl > 0) ok = lhs < rhs;
      else if (kl < 0) ok = lhs > rhs;
      else ok = d < 0;  // zero previous gain: compare sign only
      if (!ok) settled = 1'b0;
      filt_kl[i] = 32'(k[i]);
    end
    e.alt = filt_x[0];
    e.vel = filt_x[1];
    e.acc = filt_x[2];
    e.settled = settled;
    return e;
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    bit nv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        estimates_due.push_back(filter_step(baro_altitude_i));
        n_samples++;
        busy = 1'b0;
      end
      if (!busy) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 18);
        end else if (samples_pending.size() > 0) begin
          baro_altitude_i <= samples_pending.pop_front();
          nv = 1'b1;
        end
        in_valid_i <= nv;
      end
    end
  end

  // estimate monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_estimates++;
        if (gain_settled_o) n_settled++;
        if (estimates_due.size() == 0) begin
          $error("estimate word with none expected");
          n_errors++;
        end else begin
          e = estimates_due.pop_front();
          if (est_altitude_o !== e.alt) begin
            $error("est_altitude: expected %0d, got %0d", e.alt, est_altitude_o);
            n_errors++;
          end
          if (est_velocity_o !== e.vel) begin
            $error("est_velocity: expected %0d, got %0d", e.vel, est_velocity_o);
            n_errors++;
          end
          if (est_accel_o !== e.acc) begin
            $error("est_accel: expected %0d, got %0d", e.acc, est_accel_o);
            n_errors++;
          end
          if (gain_settled_o !== e.settled) begin
            $error("gain_settled: expected %0b, got %0b", e.settled, gain_settled_o);
            n_errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("altitude_kalman_filter verification failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TIME_STEP: filt_cfg.time_step         = val[30:0];
      REG_HALF_STEP: filt_cfg.half_step_squared = val[30:0];
      REG_MEAS_GAIN: filt_cfg.meas_gain         = val;
      REG_MEAS_VAR:  filt_cfg.meas_variance     = val[30:0];
      REG_Q_POS:     filt_cfg.q_position        = val[30:0];
      REG_Q_VEL:     filt_cfg.q_velocity        = val[30:0];
      REG_Q_ACC:     filt_cfg.q_acceleration    = val[30:0];
      REG_PRECISION: filt_cfg.settle_precision  = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] dt, logic [31:0] hs, logic [31:0] g,
                               logic [31:0] r, logic [31:0] qp, logic [31:0] qv,
                               logic [31:0] qa, logic [31:0] prec);
    reg_write(REG_TIME_STEP, dt);
    reg_write(REG_HALF_STEP, hs);
    reg_write(REG_MEAS_GAIN, g);
    reg_write(REG_MEAS_VAR, (r[30:0] == 0) ? 32'd1 : r);
    reg_write(REG_Q_POS, qp);
    reg_write(REG_Q_VEL, qv);
    reg_write(REG_Q_ACC, qa);
    reg_write(REG_PRECISION, prec);
    n_settings++;
  endtask

  task automatic drain();
    while (samples_pending.size() > 0 || estimates_due.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // climb/descent profile with sensor noise, and now and then a wild sample
  task automatic queue_flight(int unsigned n);
    int alt, vel, acc;
    alt = $urandom_range(0, 2000) * 65536 - 500 * 65536;
    vel = int'($urandom_range(0, 200 * 65536)) - 100 * 65536;
    acc = int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        samples_pending.push_back($urandom);
      end else begin
        vel += acc / 64;
        alt += vel / 64;
        samples_pending.push_back(alt + int'($urandom_range(0, 65536)) - 32768);
      end
    end
  endtask

  task automatic random_settings();
    if ($urandom_range(0, 2) != 0)
      load_settings($urandom_range(1, 6554), $urandom_range(0, 400),
                    $urandom_range(0, 3) == 0 ? -($urandom_range(1, 131072))
                                              : $urandom_range(1, 131072),
                    $urandom_range(1, 1 << 20), $urandom_range(0, 1 << 18),
                    $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18),
                    $urandom_range(0, 65536));
    else
      load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
  endtask

  initial begin
    filt_cfg = '{RST_TIME_STEP, RST_HALF_STEP, RST_MEAS_GAIN, RST_MEAS_VAR,
                 RST_Q, RST_Q, RST_Q, RST_PRECISION};
    filt_x   = '{XINIT_Q, 0, 0};
    filt_kl  = '{HALF_Q, HALF_Q, HALF_Q};
    for (int i = 0; i < 9; i++) filt_p[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: first sample seeds the covariance, then field extremes
    samples_pending = '{32'sd6554, 32'sd0, 32'h7fff_ffff, 32'h8000_0000, 32'sd1, -32'sd1,
                        32'h5555_5555, 32'haaaa_aaaa, 32'sd65536, 32'sd655360,
                        32'sd655360, 32'sd655360, 32'sd655360, 32'sd655360};
    drain();
    // zero measurement gain: gain stays zero, previous gain becomes zero
    load_settings(0, 0, 0, 1, 0, 0, 0, 0);
    samples_pending = '{32'sd100, 32'h7fff_ffff, 32'h8000_0000, 32'sd0};
    drain();
    // saturating extremes
    load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    samples_pending = '{32'h7fff_ffff, 32'h8000_0000, 32'sd0, 32'sd1234567};
    drain();
    load_settings(655, 3, 32'h7fff_ffff, 1, 65536, 65536, 65536, 655);
    samples_pending = '{32'h8000_0000, 32'h7fff_ffff, 32'sd0};
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) idle_on = 1'b0;
      if (ph == 0)
        load_settings(RST_TIME_STEP, RST_HALF_STEP, RST_MEAS_GAIN, RST_MEAS_VAR,
                      RST_Q, RST_Q, RST_Q, RST_PRECISION);
      else
        random_settings();
      queue_flight(109);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("%0d altitude samples run through %0d register settings; %0d settled",
             n_samples, n_settings, n_settled);
    $display("%0d estimates compared", n_estimates);
    if (n_errors == 0 && estimates_due.size() == 0) begin
      $display("altitude_kalman_filter verification clean");
    end else begin
      $display("altitude_kalman_filter verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/akf_pkg.sv
src/akf_ram.sv
src/akf_div.sv
src/akf_ctrl.sv
src/akf_dp.sv
src/altitude_kalman_filter.sv
sim/testbench.sv
